/* src/assert_macros.svh */
// Assertion macros used by the RTL top level of the sorted-event PWM block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an expression holds at every clock edge out of reset.
`define ASSERT_INV(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_INV(label, clk, rst, expr)
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/mspwm_pkg.sv */
// Types and constants of the sorted-event PWM block.
// No dependencies; used by the cell and the top level.
package mspwm_pkg;

  localparam int IN_PIN_W  = 8;
  localparam int PIN_W     = 5;
  localparam int DUTY_W    = 10;
  localparam int UNIT_W    = 16;
  localparam int RELOAD_W  = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] RESET_PERIOD_LEN = 10'd100;
  localparam logic [UNIT_W-1:0] RESET_UNIT_TICKS = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS = 2'd1;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_REMOVE = 2'd1;
  localparam cell_op_t CELL_INSERT = 2'd2;

  typedef struct packed {
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PIN_W-1:0]  key_pin;
    logic [DUTY_W-1:0] key_duty;
  } cell_cmd_t;

  typedef struct packed {
    logic                func;
    logic [IN_PIN_W-1:0] pin;
    logic [DUTY_W-1:0]   duty;
  } cmd_item_t;

  typedef struct packed {
    logic                drive_valid;
    logic [PIN_W-1:0]    pin_out;
    logic                level;
    logic                reload_valid;
    logic [RELOAD_W-1:0] reload_count;
    logic                last;
  } res_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] addr;
    logic [UNIT_W-1:0]    wdata;
  } cfg_write_t;

endpackage

/* src/mspwm_stream_if.sv */
// Valid/ready channel carrying one payload item per transfer.
// Payload type is a parameter; no package dependency.
interface mspwm_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/mspwm_cell.sv */
// One slot of the sorted duty table: holds a pin and its duty.
// Depends on mspwm_pkg; shifts to or from its neighbours on remove and insert.
module mspwm_cell
  import mspwm_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      valid,
  input  logic      below_match,
  input  logic      prev_lt,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      match,
  output logic      lt
);

  assign match = valid && (ent.pin == cmd.key_pin);
  assign lt    = valid && (ent.duty < cmd.key_duty);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_REMOVE: begin
        // close the gap left by the removed pin
        if (valid && below_match) begin
          ent <= next_ent;
        end
      end
      CELL_INSERT: begin
        if (!lt) begin
          if (prev_lt) begin
            ent <= '{pin: cmd.key_pin, duty: cmd.key_duty};
          end else begin
            ent <= prev_ent;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/multichannel_sorted_event_pwm.sv */
// Sorted-event PWM top level: command FSM over a row of table cells.
// Depends on mspwm_pkg, mspwm_stream_if, mspwm_cell and assert_macros.svh.
//
//   channel | dir | payload                                   | transfer when
//   cmd     | in  | func, pin, duty                           | valid & ready
//   res     | out | drive_valid, pin_out, level, reload_*, last | valid & ready
//   cfg     | in  | addr, wdata                               | valid & ready
//
// Set-duty: accept, remove, then insert or one steady-level result before
// ready returns; a pin out of range is dropped at accept and ready stays high.
// Expiry: a serial walk over the cell row through a single read selector;
// a low run goes through cur, scan and step before its results, a new period
// goes straight to step, and one result per pin is emitted, each when res is free.
// Reset clears control state only; table slots hold no reset value.
// A stalled result holds the FSM; cfg is always ready.
`include "assert_macros.svh"

module multichannel_sorted_event_pwm
  import mspwm_pkg::*;
#(
  parameter int PINS = 20
)
(
  input  logic           clk,
  input  logic           rst,
  mspwm_stream_if.sink   cmd,
  mspwm_stream_if.source res,
  mspwm_stream_if.sink   cfg
);

  localparam int IDX_W = $clog2(PINS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REMOVE = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_STEADY = 3'd3;
  localparam logic [2:0] S_CUR    = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_STEP   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]          state;
  cmd_item_t           cmd_reg;
  logic [IDX_W-1:0]    count;
  logic [IDX_W-1:0]    position;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    end_idx;
  logic                hi_mode;
  logic [DUTY_W-1:0]   cur;
  logic [DUTY_W-1:0]   step;
  logic [DUTY_W-1:0]   period_len;
  logic [UNIT_W-1:0]   unit_ticks;
  logic                out_valid;
  res_item_t           out_data;

  cell_cmd_t           cell_cmd;
  entry_t              ents     [PINS];
  entry_t              prev_ent [PINS];
  entry_t              next_ent [PINS];
  logic [PINS-1:0]     valid_vec;
  logic [PINS-1:0]     match_vec;
  logic [PINS-1:0]     lt_vec;
  logic [PINS-1:0]     below;
  logic [PINS-1:0]     prev_lt;

  entry_t              rd_ent;
  logic                rd_in;
  logic [DUTY_W-1:0]   nxt;
  logic                out_free;
  logic                load_out;
  logic                last_pin;
  logic [RELOAD_W-1:0] reload;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.data  = out_data;
  assign out_free  = !out_valid || res.ready;
  assign load_out  = out_free && (state == S_STEADY || state == S_EMIT);

  assign cell_cmd.op = (state == S_REMOVE) ? CELL_REMOVE :
                       (state == S_INSERT && count < IDX_W'(PINS)) ? CELL_INSERT :
                       CELL_HOLD;
  assign cell_cmd.key_pin  = cmd_reg.pin[PIN_W-1:0];
  assign cell_cmd.key_duty = cmd_reg.duty;

  for (genvar j = 0; j < PINS; j++) begin : g_cell
    assign valid_vec[j] = IDX_W'(j) < count;
    assign below[j]     = |match_vec[j:0];
    if (j == 0) begin : g_first
      // a virtual lower-duty entry sits below the first slot
      assign prev_lt[j]  = 1'b1;
      assign prev_ent[j] = ents[j];
    end else begin : g_mid
      assign prev_lt[j]  = lt_vec[j-1];
      assign prev_ent[j] = ents[j-1];
    end
    if (j == PINS - 1) begin : g_end
      assign next_ent[j] = ents[j];
    end else begin : g_inner
      assign next_ent[j] = ents[j+1];
    end

    mspwm_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .valid       (valid_vec[j]),
      .below_match (below[j]),
      .prev_lt     (prev_lt[j]),
      .prev_ent    (prev_ent[j]),
      .next_ent    (next_ent[j]),
      .ent         (ents[j]),
      .match       (match_vec[j]),
      .lt          (lt_vec[j])
    );
  end

  always_comb begin
    rd_ent = '0;
    for (int j = 0; j < PINS; j++) begin
      if (rd_idx == IDX_W'(j)) begin
        rd_ent = ents[j];
      end
    end
  end

  assign rd_in    = rd_idx < count;
  assign nxt      = rd_in ? rd_ent.duty : period_len;
  assign last_pin = ({1'b0, rd_idx} + (IDX_W + 1)'(1)) == {1'b0, end_idx};
  assign reload   = RELOAD_W'(step) * RELOAD_W'(unit_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_len <= RESET_PERIOD_LEN;
      unit_ticks <= RESET_UNIT_TICKS;
    end else if (cfg.valid) begin
      case (cfg.data.addr)
        REG_PERIOD_LEN: period_len <= cfg.data.wdata[DUTY_W-1:0];
        REG_UNIT_TICKS: unit_ticks <= cfg.data.wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      position  <= '0;
      rd_idx    <= '0;
      hi_mode   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_reg <= cmd.data;
            if (cmd.data.func) begin
              if (position >= count) begin
                hi_mode  <= 1'b1;
                position <= '0;
                rd_idx   <= '0;
                state    <= S_STEP;
              end else begin
                hi_mode <= 1'b0;
                rd_idx  <= position;
                state   <= S_CUR;
              end
            end else if (cmd.data.pin < IN_PIN_W'(PINS)) begin
              state <= S_REMOVE;
            end
          end
        end
        S_REMOVE: begin
          if (|match_vec) begin
            count <= count - IDX_W'(1);
          end
          if (cmd_reg.duty == '0 || cmd_reg.duty >= period_len) begin
            state <= S_STEADY;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (count < IDX_W'(PINS)) begin
            count <= count + IDX_W'(1);
          end
          state <= S_IDLE;
        end
        S_STEADY: begin
          if (out_free) begin
            out_data  <= '{drive_valid: 1'b1, pin_out: cmd_reg.pin[PIN_W-1:0],
                           level: (cmd_reg.duty != '0), reload_valid: 1'b0,
                           reload_count: '0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_CUR: begin
          cur    <= rd_ent.duty;
          rd_idx <= rd_idx + IDX_W'(1);
          state  <= S_SCAN;
        end
        S_SCAN: begin
          // advance past the run of entries that share the current duty
          if (rd_in && rd_ent.duty == cur) begin
            rd_idx <= rd_idx + IDX_W'(1);
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (hi_mode) begin
            step    <= (nxt == '0) ? DUTY_W'(1) : nxt;
            end_idx <= count;
            rd_idx  <= '0;
          end else begin
            step     <= (nxt > cur) ? (nxt - cur) : DUTY_W'(1);
            end_idx  <= rd_idx;
            rd_idx   <= position;
            position <= rd_idx;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (rd_idx >= end_idx) begin
              // empty table: the reload travels alone
              out_data <= '{drive_valid: 1'b0, pin_out: '0, level: 1'b0,
                            reload_valid: 1'b1, reload_count: reload, last: 1'b1};
              state    <= S_IDLE;
            end else begin
              out_data <= '{drive_valid: 1'b1, pin_out: rd_ent.pin, level: hi_mode,
                            reload_valid: last_pin,
                            reload_count: last_pin ? reload : '0,
                            last: last_pin};
              rd_idx   <= rd_idx + IDX_W'(1);
              if (last_pin) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_INV(a_count_bound, clk, rst, count <= IDX_W'(PINS))
  `ASSERT_IMP(a_reload_on_last, clk, rst, res.valid && res.data.reload_valid, res.data.last)
  `ASSERT_IMP(a_undriven_has_reload, clk, rst, res.valid && !res.data.drive_valid, res.data.reload_valid)
  `ASSERT_NEXT(a_bad_pin_ignored, clk, rst, cmd.valid && cmd.ready && !cmd.data.func && cmd.data.pin >= IN_PIN_W'(PINS), $stable(count) && state == S_IDLE)

endmodule

/* tb/sv/mspwm_tb_pkg.sv */
`timescale 1ns / 1ps
// Command codes and sizes shared by the sorted-event PWM testbench files.
// Depends on mspwm_pkg for the register index width.
package mspwm_tb_pkg;

  localparam logic FUNC_SET    = 1'b0;
  localparam logic FUNC_EXPIRE = 1'b1;

  localparam int TB_PINS = 20;

  // index with no register behind it; writes to it change nothing
  localparam logic [mspwm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

endpackage

/* tb/sv/mspwm_event_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted-event PWM block: watches cmd, cfg and res transfers,
// keeps its own pin table and compares every result. Depends on mspwm_pkg, mspwm_tb_pkg.
module mspwm_event_checker
  import mspwm_pkg::*;
  import mspwm_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_ready,
  input  cmd_item_t  cmd_data,
  input  logic       res_valid,
  input  logic       res_ready,
  input  res_item_t  res_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  cfg_write_t cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [PIN_W-1:0]  tbl_pin  [TB_PINS+1];
  logic [DUTY_W-1:0] tbl_duty [TB_PINS+1];
  int                tbl_len;   // active entries
  int                step_idx;
  logic [DUTY_W-1:0] period_r;
  logic [UNIT_W-1:0] unit_r;
  res_item_t         pending_results [$];
  int                mismatches;

  function automatic void add_result(input logic dv, input logic [PIN_W-1:0] p,
                                     input logic lv, input logic lst);
    res_item_t r;
    r = '0;
    r.drive_valid = dv;
    r.pin_out     = p;
    r.level       = lv;
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_pin(input logic [PIN_W-1:0] p);
    int i;
    i = 0;
    while (i < tbl_len && tbl_pin[i] != p) i++;
    if (i < tbl_len) begin
      for (int j = i; j + 1 < tbl_len; j++) begin
        tbl_pin[j]  = tbl_pin[j+1];
        tbl_duty[j] = tbl_duty[j+1];
      end
      tbl_len--;
    end
  endfunction

  function automatic void place_pin(input logic [PIN_W-1:0] p, input logic [DUTY_W-1:0] d);
    int i;
    if (tbl_len >= TB_PINS) return;
    // stop at the first entry not below the new duty: equal duties go after it
    i = 0;
    while (i < tbl_len && tbl_duty[i] < d) i++;
    for (int j = tbl_len; j > i; j--) begin
      tbl_pin[j]  = tbl_pin[j-1];
      tbl_duty[j] = tbl_duty[j-1];
    end
    tbl_pin[i]  = p;
    tbl_duty[i] = d;
    tbl_len++;
  endfunction

  function automatic void predict_pwm_item(input cmd_item_t it);
    int        first;
    int        cur;
    int        nxt;
    int        step;
    int        reload;
    res_item_t r;
    if (it.func == FUNC_SET) begin
      if (it.pin >= TB_PINS) return;
      drop_pin(it.pin[PIN_W-1:0]);
      if (it.duty == '0) add_result(1'b1, it.pin[PIN_W-1:0], 1'b0, 1'b1);
      else if (it.duty >= period_r) add_result(1'b1, it.pin[PIN_W-1:0], 1'b1, 1'b1);
      else place_pin(it.pin[PIN_W-1:0], it.duty);
      return;
    end
    first = pending_results.size();
    if (step_idx >= tbl_len) begin
      // new period: every listed pin goes high
      step_idx = 0;
      for (int k = 0; k < tbl_len; k++) add_result(1'b1, tbl_pin[k], 1'b1, 1'b0);
      step = (tbl_len > 0) ? int'(tbl_duty[0]) : int'(period_r);
      if (step == 0) step = 1;
    end else begin
      cur = int'(tbl_duty[step_idx]);
      while (step_idx < tbl_len && int'(tbl_duty[step_idx]) == cur) begin
        add_result(1'b1, tbl_pin[step_idx], 1'b0, 1'b0);
        step_idx++;
      end
      nxt  = (step_idx < tbl_len) ? int'(tbl_duty[step_idx]) : int'(period_r);
      step = (nxt > cur) ? nxt - cur : 1;
    end
    reload = step * int'(unit_r);
    if (pending_results.size() == first) add_result(1'b0, '0, 1'b0, 1'b0);
    r = pending_results.pop_back();
    r.reload_valid = 1'b1;
    r.reload_count = reload[RELOAD_W-1:0];
    r.last         = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void check_result(input res_item_t got);
    res_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: dv=%0d pin=%0d lvl=%0d rv=%0d rc=%0d last=%0d",
                 got.drive_valid, got.pin_out, got.level, got.reload_valid,
                 got.reload_count, got.last);
      return;
    end
    want = pending_results.pop_front();
    if (got.drive_valid !== want.drive_valid || got.pin_out !== want.pin_out ||
        got.level !== want.level || got.reload_valid !== want.reload_valid ||
        got.reload_count !== want.reload_count || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected dv=%0d pin=%0d lvl=%0d rv=%0d rc=%0d last=%0d, got dv=%0d pin=%0d lvl=%0d rv=%0d rc=%0d last=%0d",
                 want.drive_valid, want.pin_out, want.level, want.reload_valid,
                 want.reload_count, want.last,
                 got.drive_valid, got.pin_out, got.level, got.reload_valid,
                 got.reload_count, got.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tbl_len    = 0;
      step_idx   = 0;
      period_r   = RESET_PERIOD_LEN;
      unit_r     = RESET_UNIT_TICKS;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (res_valid && res_ready) check_result(res_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_data.addr == REG_PERIOD_LEN) period_r = cfg_data.wdata[DUTY_W-1:0];
        else if (cfg_data.addr == REG_UNIT_TICKS) unit_r = cfg_data.wdata;
      end
      if (cmd_valid && cmd_ready) predict_pwm_item(cmd_data);
    end
    pending    <= pending_results.size();
    fail_count <= mismatches;
  end

endmodule

/* tb/sv/multichannel_sorted_event_pwm_tb.sv */
`timescale 1ns / 1ps
// Top of the sorted-event PWM testbench: clock, reset, stimulus and verdict.
// Depends on mspwm_pkg, mspwm_stream_if, mspwm_tb_pkg, mspwm_event_checker and the block.
module multichannel_sorted_event_pwm_tb;
  import mspwm_pkg::*;
  import mspwm_tb_pkg::*;

  localparam int DRAIN_CYCLES = 2 * TB_PINS + 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst;
  logic              calm;      // no idling on either side
  logic              hold_req;  // toggle to start a long receiver hold-off
  logic [DUTY_W-1:0] cur_period;
  int                fail_count;
  int                pending;
  int                cycles = 0;

  mspwm_stream_if #(.item_t(cmd_item_t))  cmd_if ();
  mspwm_stream_if #(.item_t(res_item_t))  res_if ();
  mspwm_stream_if #(.item_t(cfg_write_t)) cfg_if ();

  multichannel_sorted_event_pwm #(.PINS(TB_PINS)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  mspwm_event_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_if.valid),
    .cmd_ready  (cmd_if.ready),
    .cmd_data   (cmd_if.data),
    .res_valid  (res_if.valid),
    .res_ready  (res_if.ready),
    .res_data   (res_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result receiver
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic send(input logic func, input logic [IN_PIN_W-1:0] pin,
                      input logic [DUTY_W-1:0] duty);
    cmd_item_t item;
    item.func = func;
    item.pin  = pin;
    item.duty = duty;
    while (!calm && $urandom_range(99) < 34) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= item;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  task automatic send_set(input logic [IN_PIN_W-1:0] pin, input logic [DUTY_W-1:0] duty);
    send(FUNC_SET, pin, duty);
  endtask

  task automatic send_expire();
    // pin and duty are don't-care here; keep them moving
    send(FUNC_EXPIRE, IN_PIN_W'($urandom), DUTY_W'($urandom));
  endtask

  // drop valid, wait for every result, then let a walk with no result finish
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNIT_W-1:0] val);
    cfg_write_t w;
    w.addr  = idx;
    w.wdata = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic configure(input logic [DUTY_W-1:0] period, input logic [UNIT_W-1:0] unit);
    settle();
    write_reg(REG_PERIOD_LEN, UNIT_W'(period));
    write_reg(REG_UNIT_TICKS, unit);
    cfg_if.valid <= 1'b0;
    cur_period = period;
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty(input logic [DUTY_W-1:0] period);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 22) return DUTY_W'($urandom_range(1023, int'(period)));
    if (period < 2) return DUTY_W'($urandom_range(1023, 1));
    return DUTY_W'($urandom_range(int'(period) - 1, 1));
  endfunction

  task automatic random_item(inout int counted);
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_expire();
      counted++;
    end else if (r < 48) begin
      // out-of-range pin: ignored, not counted
      send_set(IN_PIN_W'($urandom_range(255, TB_PINS)), DUTY_W'($urandom));
    end else begin
      send_set(IN_PIN_W'($urandom_range(TB_PINS - 1, 0)), pick_duty(cur_period));
      counted++;
    end
  endtask

  initial begin : stimulus
    int counted;
    rst          <= 1'b1;
    calm         <= 1'b0;
    hold_req     <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    cur_period = RESET_PERIOD_LEN;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: a lone reload
    send_expire();
    send_set(8'd255, 10'd1023);
    send_set(8'd20, 10'd5);
    send_set(8'd0, 10'd0);
    send_set(8'd19, 10'd1023);
    send_set(8'd3, 10'd100);
    send_set(8'd5, 10'd30);
    send_set(8'd7, 10'd30);
    send_set(8'd1, 10'd99);
    send_set(8'd2, 10'd1);
    repeat (3) send_expire();
    // move a pin mid-period, then clear one
    send_set(8'd7, 10'd60);
    send_set(8'd1, 10'd0);
    repeat (3) send_expire();
    // shrink the table behind the step position
    send_set(8'd2, 10'd0);
    send_set(8'd5, 10'd0);
    send_expire();

    // spare index, then a period of two with the largest unit
    settle();
    write_reg(REG_SPARE, 16'hffff);
    write_reg(REG_PERIOD_LEN, 16'd2);
    write_reg(REG_UNIT_TICKS, 16'hffff);
    cfg_if.valid <= 1'b0;
    cur_period = 10'd2;
    send_set(8'd4, 10'd1);
    repeat (3) send_expire();

    configure(10'd1023, 16'd0);
    send_set(8'd9, 10'd1022);
    send_set(8'd10, 10'd1023);
    repeat (2) send_expire();

    configure(10'd0, 16'd1);
    send_set(8'd11, 10'd500);
    send_expire();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure(DUTY_W'($urandom_range(1023, 2)), UNIT_W'($urandom_range(65535, 1)));
        1: configure(DUTY_W'($urandom_range(8, 3)), UNIT_W'($urandom_range(300, 1)));
        2: configure(DUTY_W'($urandom_range(1023, 200)), UNIT_W'($urandom_range(65535, 1)));
        default: configure(DUTY_W'($urandom_range(150, 2)), UNIT_W'($urandom_range(65535, 1)));
      endcase
      calm <= (ph == 1);
      counted = 0;
      if (ph == 2) begin
        // fill every pin, then stall the receiver while expiries pile up
        for (int p = 0; p < TB_PINS; p++)
          send_set(IN_PIN_W'(p), DUTY_W'($urandom_range(int'(cur_period) - 1, 1)));
        hold_req <= ~hold_req;
        repeat (8) send_expire();
        counted = 24;
      end
      while (counted < 24) random_item(counted);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
